// ===== rtl/core/pip_pkg.sv =====
// Shared types, constants and helpers for the pack index parser.
// No dependencies; pip_cfg, pip_core, pip_fifo and the top level refer to this package.
`default_nettype none

package pip_pkg;

  // Header and entry layout
  localparam int MAGIC_LEN   = 4;   // "TCPK"
  localparam int COUNT_POS   = 8;   // first byte of the entry count
  localparam int HDR_BYTES   = 12;  // magic + version + count
  localparam int LEN_BYTES   = 4;   // key length field
  localparam int TRAIL_BYTES = 16;  // offset + length fields

  // Result field widths
  localparam int SLICE_W = 48;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = 2;
  localparam int FIFO_CW    = 3;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;
  typedef logic [CFG_AW-4:0] reg_idx_t;
  localparam reg_idx_t REG_PACK_SIZE = reg_idx_t'(0);

  typedef enum logic [2:0] {
    KIND_KEY   = 3'd0,
    KIND_ENTRY = 3'd1,
    KIND_OK    = 3'd2,
    KIND_SMALL = 3'd3,
    KIND_MAGIC = 3'd4,
    KIND_TRUNC = 3'd5,
    KIND_SLICE = 3'd6
  } kind_t;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_HEADER = 7'b0000010,
    PH_KEYLEN = 7'b0000100,
    PH_KEY    = 7'b0001000,
    PH_OFFSET = 7'b0010000,
    PH_LENGTH = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         key_char;
    logic [31:0]        entry_number;
    logic [SLICE_W-1:0] slice_offset;
    logic [SLICE_W-1:0] slice_length;
    logic               last_in_run;
  } res_t;

  // Results produced by one byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Result queue status
  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               room;
  } fifo_stat_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h54;
      2'd1:    b = 8'h43;
      2'd2:    b = 8'h50;
      default: b = 8'h4B;
    endcase
    return b;
  endfunction

  function automatic res_t mk_res(input kind_t k, input logic [7:0] ch,
                                  input logic [31:0] ent, input logic [63:0] off,
                                  input logic [63:0] len);
    res_t r;
    r.kind         = k;
    r.key_char     = ch;
    r.entry_number = ent;
    r.slice_offset = off[SLICE_W-1:0];
    r.slice_length = len[SLICE_W-1:0];
    r.last_in_run  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pip_in_if.sv =====
// Byte input channel of the pack index parser: valid/ready plus payload.
// Stand-alone; no package needed.
`default_nettype none

interface pip_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_pack;
  logic [7:0] data_byte;

  modport source (output valid, output start_of_pack, output data_byte, input ready);
  modport sink   (input valid, input start_of_pack, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pip_out_if.sv =====
// Result channel of the pack index parser: valid/ready plus result fields.
// Stand-alone; no package needed.
`default_nettype none

interface pip_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  key_char;
  logic [31:0] entry_number;
  logic [47:0] slice_offset;
  logic [47:0] slice_length;
  logic        last_in_run;

  modport source (output valid, output kind, output key_char, output entry_number,
                  output slice_offset, output slice_length, output last_in_run,
                  input ready);
  modport sink   (input valid, input kind, input key_char, input entry_number,
                  input slice_offset, input slice_length, input last_in_run,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pip_cfg.sv =====
// APB-style register file holding the pack size.
// Depends on pip_pkg.
`default_nettype none

module pip_cfg #(
  parameter int SIZE_BITS = 48
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pip_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [pip_pkg::CFG_DW-1:0]   pwdata,
  output logic      [pip_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready,
  output logic      [SIZE_BITS-1:0]         pack_size
);

  logic [SIZE_BITS-1:0] pack_size_r;
  pip_pkg::reg_idx_t    idx;
  logic                 wr_en;

  // 8-byte register spacing
  assign idx    = paddr[pip_pkg::CFG_AW-1:3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_size_r <= '0;
    end else if (wr_en && idx == pip_pkg::REG_PACK_SIZE) begin
      pack_size_r <= pwdata[SIZE_BITS-1:0];
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      pip_pkg::REG_PACK_SIZE: prdata = pip_pkg::CFG_DW'(pack_size_r);
      default:                prdata = '0;
    endcase
  end

  assign pack_size = pack_size_r;

endmodule

`default_nettype wire

// ===== rtl/core/pip_core.sv =====
// Input byte register and the single-pass parser: header, key length, key,
// offset and length fields, bounds checks. Depends on pip_pkg.
`default_nettype none

module pip_core #(
  parameter int SIZE_BITS = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [SIZE_BITS-1:0] pack_size,
  input  wire logic                 in_valid,
  input  wire logic                 in_sop,
  input  wire logic [7:0]           in_byte,
  output logic                      in_ready,
  input  wire logic                 room,
  output pip_pkg::push_t            push
);

  // input register
  logic       iv_r;
  logic       sop_r;
  logic [7:0] byte_r;
  logic       adv;

  // parser state
  pip_pkg::phase_t      phase_r, phase_nxt;
  logic [2:0]           fbc_r, fbc_nxt;
  logic [SIZE_BITS-1:0] pos_r, pos_nxt;
  logic [63:0]          shift_r, shift_nxt;
  logic [31:0]          key_r, key_nxt;
  logic [31:0]          ent_r, ent_nxt;
  logic [31:0]          idx_r, idx_nxt;
  logic [63:0]          saved_r, saved_nxt;

  // state as seen by this byte (a start byte clears it first)
  pip_pkg::phase_t      c_phase;
  logic [2:0]           c_fbc;
  logic [SIZE_BITS-1:0] c_pos;
  logic [63:0]          c_shift;
  logic [31:0]          c_key, c_ent, c_idx;
  logic [63:0]          c_saved;

  logic [SIZE_BITS-1:0] pos_n;
  logic [63:0]          pos64, psz64;
  logic [63:0]          col_shift, hdr_shift;
  logic [2:0]           col_fbc;
  logic                 ent_trunc, key_trunc, slice_bad;
  logic [31:0]          idx_inc, ent_dec, key_dec;
  logic [1:0]           n;
  pip_pkg::res_t        ra, rb;

  assign adv      = iv_r & room;
  assign in_ready = ~iv_r | adv;

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      iv_r <= 1'b1;
    end else if (adv) begin
      iv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sop_r  <= in_sop;
      byte_r <= in_byte;
    end
  end

  // next state and results for the registered byte
  always_comb begin
    c_phase = sop_r ? pip_pkg::PH_HEADER : phase_r;
    c_fbc   = sop_r ? 3'd0  : fbc_r;
    c_pos   = sop_r ? '0    : pos_r;
    c_shift = sop_r ? 64'd0 : shift_r;
    c_key   = sop_r ? 32'd0 : key_r;
    c_ent   = sop_r ? 32'd0 : ent_r;
    c_idx   = sop_r ? 32'd0 : idx_r;
    c_saved = sop_r ? 64'd0 : saved_r;

    pos_n     = c_pos + 1'b1;
    pos64     = 64'(pos_n);
    psz64     = 64'(pack_size);
    col_shift = c_shift | (64'(byte_r) << {c_fbc, 3'b000});
    col_fbc   = c_fbc + 3'd1;
    hdr_shift = c_shift | (64'(byte_r) << {c_pos[1:0], 3'b000});
    ent_trunc = (pos64 + 64'(pip_pkg::LEN_BYTES)) > psz64;
    key_trunc = (pos64 + 64'(col_shift[31:0]) + 64'(pip_pkg::TRAIL_BYTES)) > psz64;
    slice_bad = (c_saved > psz64) || (col_shift > (psz64 - c_saved)) || (c_saved < pos64);
    idx_inc   = c_idx + 32'd1;
    ent_dec   = c_ent - 32'd1;
    key_dec   = c_key - 32'd1;

    phase_nxt = c_phase;
    fbc_nxt   = c_fbc;
    pos_nxt   = c_pos;
    shift_nxt = c_shift;
    key_nxt   = c_key;
    ent_nxt   = c_ent;
    idx_nxt   = c_idx;
    saved_nxt = c_saved;

    n  = 2'd0;
    ra = pip_pkg::mk_res(pip_pkg::KIND_KEY, 8'd0, 32'd0, 64'd0, 64'd0);
    rb = ra;

    if (sop_r && psz64 < 64'(pip_pkg::HDR_BYTES)) begin
      // pack cannot even hold a header
      n         = 2'd1;
      ra        = pip_pkg::mk_res(pip_pkg::KIND_SMALL, 8'd0, 32'd0, 64'd0, 64'd0);
      phase_nxt = pip_pkg::PH_DONE;
    end else if (c_phase != pip_pkg::PH_IDLE && c_phase != pip_pkg::PH_DONE) begin
      pos_nxt = pos_n;
      unique case (c_phase)
        pip_pkg::PH_HEADER: begin
          if (c_pos < SIZE_BITS'(pip_pkg::MAGIC_LEN)) begin
            if (byte_r != pip_pkg::magic_byte(c_pos[1:0])) begin
              n         = 2'd1;
              ra        = pip_pkg::mk_res(pip_pkg::KIND_MAGIC, 8'd0, 32'd0, 64'd0, 64'd0);
              phase_nxt = pip_pkg::PH_DONE;
            end
          end else if (c_pos >= SIZE_BITS'(pip_pkg::COUNT_POS)) begin
            shift_nxt = hdr_shift;
            if (c_pos >= SIZE_BITS'(pip_pkg::HDR_BYTES - 1)) begin
              ent_nxt   = hdr_shift[31:0];
              shift_nxt = 64'd0;
              if (hdr_shift[31:0] == 32'd0) begin
                n         = 2'd1;
                ra        = pip_pkg::mk_res(pip_pkg::KIND_OK, 8'd0, 32'd0, 64'd0, 64'd0);
                phase_nxt = pip_pkg::PH_DONE;
              end else if (ent_trunc) begin
                n         = 2'd1;
                ra        = pip_pkg::mk_res(pip_pkg::KIND_TRUNC, 8'd0, c_idx, 64'd0, 64'd0);
                phase_nxt = pip_pkg::PH_DONE;
              end else begin
                phase_nxt = pip_pkg::PH_KEYLEN;
                fbc_nxt   = 3'd0;
              end
            end
          end
        end
        pip_pkg::PH_KEYLEN: begin
          shift_nxt = col_shift;
          fbc_nxt   = col_fbc;
          if (col_fbc == 3'(pip_pkg::LEN_BYTES)) begin
            fbc_nxt   = 3'd0;
            key_nxt   = col_shift[31:0];
            shift_nxt = 64'd0;
            if (key_trunc) begin
              n         = 2'd1;
              ra        = pip_pkg::mk_res(pip_pkg::KIND_TRUNC, 8'd0, c_idx, 64'd0, 64'd0);
              phase_nxt = pip_pkg::PH_DONE;
            end else if (col_shift[31:0] != 32'd0) begin
              phase_nxt = pip_pkg::PH_KEY;
            end else begin
              phase_nxt = pip_pkg::PH_OFFSET;
            end
          end
        end
        pip_pkg::PH_KEY: begin
          n       = 2'd1;
          ra      = pip_pkg::mk_res(pip_pkg::KIND_KEY, byte_r, c_idx, 64'd0, 64'd0);
          key_nxt = key_dec;
          if (key_dec == 32'd0) begin
            phase_nxt = pip_pkg::PH_OFFSET;
            fbc_nxt   = 3'd0;
            shift_nxt = 64'd0;
          end
        end
        pip_pkg::PH_OFFSET: begin
          shift_nxt = col_shift;
          fbc_nxt   = col_fbc;
          if (col_fbc == 3'd0) begin
            saved_nxt = col_shift;
            shift_nxt = 64'd0;
            phase_nxt = pip_pkg::PH_LENGTH;
          end
        end
        pip_pkg::PH_LENGTH: begin
          shift_nxt = col_shift;
          fbc_nxt   = col_fbc;
          if (col_fbc == 3'd0) begin
            shift_nxt = 64'd0;
            n         = 2'd1;
            if (slice_bad) begin
              ra        = pip_pkg::mk_res(pip_pkg::KIND_SLICE, 8'd0, c_idx, 64'd0, 64'd0);
              phase_nxt = pip_pkg::PH_DONE;
            end else begin
              ra      = pip_pkg::mk_res(pip_pkg::KIND_ENTRY, 8'd0, c_idx, c_saved, col_shift);
              idx_nxt = idx_inc;
              ent_nxt = ent_dec;
              if (ent_dec == 32'd0) begin
                n         = 2'd2;
                rb        = pip_pkg::mk_res(pip_pkg::KIND_OK, 8'd0, idx_inc, 64'd0, 64'd0);
                phase_nxt = pip_pkg::PH_DONE;
              end else if (ent_trunc) begin
                n         = 2'd2;
                rb        = pip_pkg::mk_res(pip_pkg::KIND_TRUNC, 8'd0, idx_inc, 64'd0, 64'd0);
                phase_nxt = pip_pkg::PH_DONE;
              end else begin
                phase_nxt = pip_pkg::PH_KEYLEN;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // flag the final result of this byte
    if (n == 2'd1) ra.last_in_run = 1'b1;
    if (n == 2'd2) rb.last_in_run = 1'b1;

    push.n  = adv ? n : 2'd0;
    push.r0 = ra;
    push.r1 = rb;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pip_pkg::PH_IDLE;
      fbc_r   <= '0;
      pos_r   <= '0;
      shift_r <= '0;
      key_r   <= '0;
      ent_r   <= '0;
      idx_r   <= '0;
      saved_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      key_r   <= key_nxt;
      ent_r   <= ent_nxt;
      idx_r   <= idx_nxt;
      saved_r <= saved_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pip_fifo.sv =====
// Four-deep result queue: takes up to two results per cycle, gives one per cycle while pop_ready is high.
// Depends on pip_pkg.
`default_nettype none

module pip_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pip_pkg::push_t  push,
  input  wire logic            pop_ready,
  output logic                 out_valid,
  output pip_pkg::res_t        out_data,
  output pip_pkg::fifo_stat_t  stat
);

  pip_pkg::res_t                mem_r [pip_pkg::FIFO_DEPTH];
  logic [pip_pkg::FIFO_PW-1:0]  wr_r, rd_r;
  logic [pip_pkg::FIFO_CW-1:0]  count_r;
  logic                         pop;
  logic [pip_pkg::FIFO_PW-1:0]  wr_p1;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid & pop_ready;
  assign wr_p1     = wr_r + 1'b1;

  assign stat.count = count_r;
  assign stat.room  = (count_r <= pip_pkg::FIFO_CW'(pip_pkg::FIFO_DEPTH - 2));

  // storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_r]  <= push.r0;
    if (push.n == 2'd2) mem_r[wr_p1] <= push.r1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_r + pip_pkg::FIFO_PW'(push.n);
      if (pop) rd_r <= rd_r + 1'b1;
      count_r <= count_r + pip_pkg::FIFO_CW'(push.n) - pip_pkg::FIFO_CW'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pack_index_parser.sv =====
// Top level of the pack index parser: register port, parser core, result queue.
// Depends on pip_pkg, pip_in_if, pip_out_if, pip_cfg, pip_core, pip_fifo.
//
//   channel | protocol          | beat
//   in_ch   | valid/ready       | start_of_pack, data_byte
//   out_ch  | valid/ready       | kind, key_char, entry_number, slice, last_in_run
//   cfg_*   | APB write/read    | pack_size at byte address 0 (64-bit data)
//
// One byte is accepted per cycle while the queue has room. A byte is held in the
// input register, parsed there in a single pass, and its results are written into
// the 4-deep queue. Results leave one per cycle while out_ch.ready is high, so a
// byte giving two results (entry done plus pack ok or truncated) needs two transfers out.
// The input register holds its byte while the queue has fewer than two free slots.
// Reset (rst_n low, synchronous) leaves the parser idle, the queue empty and
// pack_size zero; bytes before a start_of_pack beat are dropped.
`default_nettype none

module pack_index_parser #(
  parameter int SIZE_BITS = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pip_in_if.sink                           in_ch,
  pip_out_if.source                        out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [pip_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [pip_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic      [pip_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  logic [SIZE_BITS-1:0] pack_size;
  pip_pkg::push_t       push;
  pip_pkg::fifo_stat_t  stat;
  pip_pkg::res_t        res;
  logic                 out_valid;

  pip_cfg #(.SIZE_BITS(SIZE_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .pack_size (pack_size)
  );

  pip_core #(.SIZE_BITS(SIZE_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .pack_size (pack_size),
    .in_valid  (in_ch.valid),
    .in_sop    (in_ch.start_of_pack),
    .in_byte   (in_ch.data_byte),
    .in_ready  (in_ch.ready),
    .room      (stat.room),
    .push      (push)
  );

  pip_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_data  (res),
    .stat      (stat)
  );

  // result channel
  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = res.kind;
  assign out_ch.key_char     = res.key_char;
  assign out_ch.entry_number = res.entry_number;
  assign out_ch.slice_offset = res.slice_offset;
  assign out_ch.slice_length = res.slice_length;
  assign out_ch.last_in_run  = res.last_in_run;

  // queue is only pushed when it has room for a full burst
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> stat.count <= pip_pkg::FIFO_CW'(pip_pkg::FIFO_DEPTH - 2))
    else $error("result pushed without room");

  // fill count never passes the depth
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= pip_pkg::FIFO_CW'(pip_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // draining the last entry with nothing pushed empties the channel
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ch.ready && stat.count == pip_pkg::FIFO_CW'(1) && push.n == 2'd0)
    |=> !out_valid)
    else $error("stale result after drain");

  // a two-result burst ends on its second result only
  a_burst_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> (!push.r0.last_in_run && push.r1.last_in_run))
    else $error("bad last_in_run on burst");

endmodule

`default_nettype wire
